[hdl/rhnp_pkg.sv]
// Shared types and constants for the request header and netstring parser.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rhnp_pkg;

   // Byte codes that the parser recognizes.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Role codes on the result channel.
   localparam logic [2:0] ROLE_UUID  = 3'd0;
   localparam logic [2:0] ROLE_ID    = 3'd1;
   localparam logic [2:0] ROLE_PATH  = 3'd2;
   localparam logic [2:0] ROLE_SPACE = 3'd3;
   localparam logic [2:0] ROLE_DIGIT = 3'd4;
   localparam logic [2:0] ROLE_COLON = 3'd5;
   localparam logic [2:0] ROLE_DATA  = 3'd6;
   localparam logic [2:0] ROLE_SKIP  = 3'd7;

   // Status codes on the result channel.
   localparam logic [1:0] ST_NONE   = 2'd0;
   localparam logic [1:0] ST_OK     = 2'd1;
   localparam logic [1:0] ST_HEADER = 2'd2;
   localparam logic [1:0] ST_BAD    = 2'd3;

   localparam int RSP_INDEX_BITS = 16;

   // A classified input item as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_message;
      logic       is_space;
      logic       is_colon;
      logic       is_digit;
      logic [3:0] digit;
   } class_type;

   // One result item.
   typedef struct packed {
      logic [7:0]                out_byte;
      logic [2:0]                role;
      logic [RSP_INDEX_BITS-1:0] netstring_index;
      logic                      data_last;
      logic [1:0]                status;
      logic                      last;
   } result_type;

endpackage

`default_nettype wire

[hdl/rhnp_front.sv]
// Front end: takes input items, classifies each byte and holds it in a register.
// Depends on rhnp_pkg.
`default_nettype none

module rhnp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [7:0]            req_tdata,
   input  wire                   req_tlast,
   output logic                  item_valid,
   input  wire                   item_ready,
   output rhnp_pkg::class_type   item
);
   import rhnp_pkg::*;

   logic      valid_ff, valid_in;
   class_type item_ff, item_in;
   logic      take;

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      item_in.in_byte        = req_tdata;
      item_in.end_of_message = req_tlast;
      item_in.is_space       = (req_tdata == CHAR_SPACE);
      item_in.is_colon       = (req_tdata == CHAR_COLON);
      item_in.is_digit       = (req_tdata inside {[CHAR_ZERO:CHAR_NINE]});
      item_in.digit          = 4'(req_tdata - CHAR_ZERO);
   end

   assign valid_in = take ? 1'b1 : (item_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[hdl/rhnp_queue.sv]
// Two-entry queue of classified items between the front and the back end.
// Depends on rhnp_pkg.
`default_nettype none

module rhnp_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push_valid,
   output logic                     push_ready,
   input  wire rhnp_pkg::class_type push_item,
   output logic                     pop_valid,
   input  wire                      pop_ready,
   output rhnp_pkg::class_type      pop_item
);
   import rhnp_pkg::*;

   class_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[hdl/rhnp_back.sv]
// Back end: parser state machine that tags each byte and drives the result register.
// Depends on rhnp_pkg.
`default_nettype none

module rhnp_back #(
   parameter int LENGTH_BITS = 31,
   parameter int INDEX_BITS  = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      item_valid,
   output logic                     item_ready,
   input  wire rhnp_pkg::class_type item,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output rhnp_pkg::result_type     rsp
);
   import rhnp_pkg::*;

   typedef enum logic [2:0] {
      PH_UUID, PH_ID, PH_PATH, PH_LEN, PH_DATA, PH_SEP, PH_ERR
   } phase_type;

   localparam int WIDE_BITS = LENGTH_BITS + 4;

   phase_type              phase_ff, phase_in;
   logic [INDEX_BITS-1:0]  count_ff, count_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;

   logic [WIDE_BITS-1:0]   acc_wide;
   logic [WIDE_BITS-1:0]   next_len;
   logic [LENGTH_BITS-1:0] remain_dec;
   logic [31:0]            count_wide;
   logic                   pop;

   assign item_ready = !out_valid_ff || rsp_ready;
   assign pop        = item_valid && item_ready;

   // Length times ten plus the new digit, with four spare bits to catch overflow.
   assign acc_wide   = WIDE_BITS'(acc_ff);
   assign next_len   = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(item.digit);
   assign remain_dec = remain_ff - LENGTH_BITS'(1);
   assign count_wide = 32'(count_ff);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      remain_in = remain_ff;

      out_in.out_byte        = item.in_byte;
      out_in.role            = ROLE_SKIP;
      out_in.netstring_index = count_wide[RSP_INDEX_BITS-1:0];
      out_in.data_last       = 1'b0;
      out_in.status          = ST_NONE;
      out_in.last            = item.end_of_message;

      case (phase_ff)
         PH_UUID, PH_ID, PH_PATH: begin
            if (item.is_space) begin
               out_in.role = ROLE_SPACE;
               acc_in      = '0;
               if (item.end_of_message) begin
                  out_in.status = (phase_ff == PH_PATH) ? ST_BAD : ST_HEADER;
               end
               case (phase_ff)
                  PH_UUID: phase_in = PH_ID;
                  PH_ID:   phase_in = PH_PATH;
                  default: phase_in = PH_LEN;
               endcase
            end else begin
               case (phase_ff)
                  PH_UUID: out_in.role = ROLE_UUID;
                  PH_ID:   out_in.role = ROLE_ID;
                  default: out_in.role = ROLE_PATH;
               endcase
               if (item.end_of_message) begin
                  out_in.status = ST_HEADER;
               end
            end
         end
         PH_LEN: begin
            if (item.is_digit) begin
               if (next_len[WIDE_BITS-1:LENGTH_BITS] != '0) begin
                  phase_in = PH_ERR;
               end else begin
                  acc_in      = next_len[LENGTH_BITS-1:0];
                  out_in.role = ROLE_DIGIT;
               end
            end else if (item.is_colon) begin
               // An empty length also leaves the accumulator at zero.
               if (acc_ff == '0) begin
                  phase_in = PH_ERR;
               end else begin
                  out_in.role = ROLE_COLON;
                  remain_in   = acc_ff;
                  phase_in    = PH_DATA;
               end
            end else begin
               phase_in = PH_ERR;
            end
            if (item.end_of_message) begin
               out_in.status = ST_BAD;
            end
         end
         PH_DATA: begin
            out_in.role = ROLE_DATA;
            remain_in   = remain_dec;
            if (remain_dec == '0) begin
               out_in.data_last = 1'b1;
               phase_in         = PH_SEP;
            end
            if (item.end_of_message) begin
               out_in.data_last = 1'b1;
               out_in.status    = ST_OK;
            end
         end
         PH_SEP: begin
            count_in = count_ff + INDEX_BITS'(1);
            acc_in   = '0;
            phase_in = PH_LEN;
            if (item.end_of_message) begin
               out_in.status = ST_OK;
            end
         end
         default: begin
            if (item.end_of_message) begin
               out_in.status = ST_BAD;
            end
         end
      endcase

      // The final byte of a message returns the parser to its start state.
      if (item.end_of_message) begin
         phase_in  = PH_UUID;
         count_in  = '0;
         acc_in    = '0;
         remain_in = '0;
      end
   end

   assign out_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_UUID;
         count_ff     <= '0;
         acc_ff       <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            acc_ff    <= acc_in;
            remain_ff <= remain_in;
            out_ff    <= out_in;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

`default_nettype wire

[hdl/request_header_netstring_parser.sv]
// Request header and netstring parser, top level.
// Each byte passes through the front register, the two-entry queue and the result register.
// Throughput: one byte per cycle while rsp_tready is high, set by the back end's state update.
// The two-entry queue and the result register let either side stall on its own.
// Reset (synchronous, active high) empties all stages and returns the parser to the uuid token.
// Depends on rhnp_pkg, rhnp_front, rhnp_queue and rhnp_back.
`default_nettype none

module request_header_netstring_parser #(
   parameter int LENGTH_BITS = 31,
   parameter int INDEX_BITS  = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] in_byte
   input  wire         req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [23:8] netstring_index, [25:24] status
   output logic [3:0]  rsp_tuser,   // [2:0] role, [3] data_last
   output logic        rsp_tlast    // last
);
   import rhnp_pkg::*;

   logic       front_valid, front_ready;
   class_type  front_item;
   logic       back_valid, back_ready;
   class_type  back_item;
   result_type rsp;

   rhnp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   rhnp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   rhnp_back #(
      .LENGTH_BITS (LENGTH_BITS),
      .INDEX_BITS  (INDEX_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.status, rsp.netstring_index, rsp.out_byte};
   assign rsp_tuser = {rsp.data_last, rsp.role};
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire
